// ===== sv/iisq_pkg.sv =====
// Shared constants, types and helpers for the integral / squared integral image block.
// No dependencies; every other file of the block but iisq_line_ram uses this package.
`default_nettype none
package iisq_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int DIM_W       = 11;
   localparam int PIXEL_W     = 8;
   localparam int SUM_W       = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = DIM_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);

   // one pixel on its way from the scan stage to the line-buffer update
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first_row;
      logic             frame_end;
      logic [SUM_W-1:0] row_sum;
      logic [SUM_W-1:0] row_sum_sq;
   } item_type;

   // last column index; zero reads as one pixel, oversize saturates
   function automatic logic [COL_W-1:0] last_col(input logic [DIM_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_WIDTH) begin
         r = COL_W'(MAX_WIDTH - 1);
      end else begin
         r = COL_W'(v - DIM_W'(1));
      end
      return r;
   endfunction

   function automatic logic [ROW_W-1:0] last_row(input logic [DIM_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > MAX_HEIGHT) begin
         r = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         r = ROW_W'(v - DIM_W'(1));
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/iisq_if.sv =====
// Valid/ready channel interfaces for the pixel input and the sum output.
// Depends on iisq_pkg for field widths.
`default_nettype none
interface iisq_req_if;
   import iisq_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface iisq_rsp_if;
   import iisq_pkg::*;
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] area_sum;
   logic [SUM_W-1:0] area_sum_squares;
   logic             frame_end;
   modport source (output valid, output area_sum, output area_sum_squares,
                   output frame_end, input ready);
   modport sink   (input valid, input area_sum, input area_sum_squares,
                   input frame_end, output ready);
endinterface
`default_nettype wire

// ===== sv/iisq_line_ram.sv =====
// Simple dual-port line buffer RAM, one write and one registered read per cycle.
// Stand-alone; no package dependency.
`default_nettype none
module iisq_line_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the contents before a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== sv/iisq_scan.sv =====
// Raster scan front end: frame size registers, column/row counters, running row sums.
// Issues the line-buffer read and holds one word for the update stage. Uses iisq_pkg.
`default_nettype none
module iisq_scan (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [iisq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [iisq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              req_valid,
   input  wire logic [iisq_pkg::PIXEL_W-1:0]      req_pixel,
   output      logic                              req_ready,
   input  wire logic                              item_take,
   output      logic                              rd_en,
   output      logic [iisq_pkg::COL_W-1:0]        rd_addr,
   output      logic                              item_valid,
   output      iisq_pkg::item_type                item
);
   import iisq_pkg::*;

   logic [DIM_W-1:0]     width_ff, height_ff;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [SUM_W-1:0]     row_sum_ff, row_sum_in;
   logic [SUM_W-1:0]     row_sq_ff, row_sq_in;
   logic                 item_valid_ff, item_valid_in;
   item_type             item_ff, item_in;
   logic                 accept;
   logic                 row_end, frame_done;
   logic [2*PIXEL_W-1:0] pixel_sq;
   logic [SUM_W-1:0]     sum_add, sq_add;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !item_valid_ff || item_take;
   assign accept    = req_valid && req_ready;

   assign pixel_sq   = req_pixel * req_pixel;
   assign sum_add    = row_sum_ff + SUM_W'(req_pixel);
   assign sq_add     = row_sq_ff + SUM_W'(pixel_sq);
   assign row_end    = col_ff >= last_col(width_ff);
   assign frame_done = row_end && (row_ff >= last_row(height_ff));

   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      row_sum_in    = row_sum_ff;
      row_sq_in     = row_sq_ff;
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !item_take;
      if (accept) begin
         item_valid_in     = 1'b1;
         item_in.col       = col_ff;
         item_in.first_row = (row_ff == '0);
         item_in.frame_end = frame_done;
         item_in.row_sum   = sum_add;
         item_in.row_sum_sq = sq_add;
         if (row_end) begin
            col_in     = '0;
            row_sum_in = '0;
            row_sq_in  = '0;
            row_in     = frame_done ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in     = col_ff + COL_W'(1);
            row_sum_in = sum_add;
            row_sq_in  = sq_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         row_sum_ff    <= '0;
         row_sq_ff     <= '0;
         item_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         row_sum_ff    <= row_sum_in;
         row_sq_ff     <= row_sq_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rd_en      = accept;
   assign rd_addr    = col_ff;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;
endmodule
`default_nettype wire

// ===== sv/iisq_update.sv =====
// Update stage: adds the line-buffer value above, writes the result back, output register.
// Forwards the previous result when it lands on the column being read. Uses iisq_pkg.
`default_nettype none
module iisq_update (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire iisq_pkg::item_type            item,
   output      logic                          item_take,
   input  wire logic                          rd_en,
   input  wire logic [iisq_pkg::COL_W-1:0]    rd_addr,
   input  wire logic [iisq_pkg::SUM_W-1:0]    above_sum,
   input  wire logic [iisq_pkg::SUM_W-1:0]    above_sq,
   output      logic                          wr_en,
   output      logic [iisq_pkg::COL_W-1:0]    wr_addr,
   output      logic [iisq_pkg::SUM_W-1:0]    wr_sum,
   output      logic [iisq_pkg::SUM_W-1:0]    wr_sq,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [iisq_pkg::SUM_W-1:0]    rsp_area_sum,
   output      logic [iisq_pkg::SUM_W-1:0]    rsp_area_sum_squares,
   output      logic                          rsp_frame_end
);
   import iisq_pkg::*;

   logic             fwd_hit_ff;
   logic [SUM_W-1:0] fwd_sum_ff, fwd_sq_ff;
   logic [SUM_W-1:0] up_sum, up_sq, sum, sum_sq;
   logic             out_valid_ff;
   logic [SUM_W-1:0] out_sum_ff, out_sq_ff;
   logic             out_end_ff;

   always_comb begin
      if (item.first_row) begin
         up_sum = '0;
         up_sq  = '0;
      end else if (fwd_hit_ff) begin
         up_sum = fwd_sum_ff;
         up_sq  = fwd_sq_ff;
      end else begin
         up_sum = above_sum;
         up_sq  = above_sq;
      end
   end

   assign sum       = item.row_sum + up_sum;
   assign sum_sq    = item.row_sum_sq + up_sq;
   assign item_take = item_valid && (!out_valid_ff || rsp_ready);

   assign wr_en   = item_take;
   assign wr_addr = item.col;
   assign wr_sum  = sum;
   assign wr_sq   = sum_sq;

   // a read issued on the same edge as the write to that column sees stale data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= item_take && (item.col == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         fwd_sum_ff <= sum;
         fwd_sq_ff  <= sum_sq;
         out_sum_ff <= sum;
         out_sq_ff  <= sum_sq;
         out_end_ff <= item.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (item_take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_area_sum         = out_sum_ff;
   assign rsp_area_sum_squares = out_sq_ff;
   assign rsp_frame_end        = out_end_ff;
endmodule
`default_nettype wire

// ===== sv/integral_and_squared_integral_image_top.sv =====
// Top level of the streaming integral / squared integral image block.
// Depends on iisq_pkg, iisq_if, iisq_line_ram, iisq_scan and iisq_update.
//
//   port      dir  handshake          word
//   req_if    in   valid/ready        pixel[7:0]
//   rsp_if    out  valid/ready        area_sum[31:0], area_sum_squares[31:0], frame_end
//   csr_*     in   csr_we, no ready   csr_index[0] selects width/height, csr_wdata[10:0]
//
// One pixel per clock sustained while rsp is not backpressured; from pixel accept to rsp valid
// the path is the line-buffer read, then add and write-back into the output register.
// Synchronous reset clears counters, running sums and valid flags; line buffers
// are not cleared and hold no meaning until written by row 0 of a frame.
// rsp backpressure stalls the update stage; one word stays buffered ahead of it.
`default_nettype none
module integral_and_squared_integral_image_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   iisq_req_if.sink                               req_if,
   iisq_rsp_if.source                             rsp_if,
   input  wire logic                              csr_we,
   input  wire logic [iisq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [iisq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import iisq_pkg::*;

   logic             req_ready;
   logic             item_take, item_valid;
   item_type         item;
   logic             rd_en, wr_en;
   logic [COL_W-1:0] rd_addr, wr_addr;
   logic [SUM_W-1:0] above_sum, above_sq, wr_sum, wr_sq;

   assign req_if.ready = req_ready;

   iisq_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_if.valid),
      .req_pixel  (req_if.pixel),
      .req_ready  (req_ready),
      .item_take  (item_take),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .item_valid (item_valid),
      .item       (item)
   );

   iisq_line_ram #(.DATA_W(SUM_W), .DEPTH(MAX_WIDTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_sum),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (above_sum)
   );

   iisq_line_ram #(.DATA_W(SUM_W), .DEPTH(MAX_WIDTH)) u_sq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_sq),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (above_sq)
   );

   iisq_update u_update (
      .clock                (clock),
      .reset                (reset),
      .item_valid           (item_valid),
      .item                 (item),
      .item_take            (item_take),
      .rd_en                (rd_en),
      .rd_addr              (rd_addr),
      .above_sum            (above_sum),
      .above_sq             (above_sq),
      .wr_en                (wr_en),
      .wr_addr              (wr_addr),
      .wr_sum               (wr_sum),
      .wr_sq                (wr_sq),
      .rsp_valid            (rsp_if.valid),
      .rsp_ready            (rsp_if.ready),
      .rsp_area_sum         (rsp_if.area_sum),
      .rsp_area_sum_squares (rsp_if.area_sum_squares),
      .rsp_frame_end        (rsp_if.frame_end)
   );
endmodule
`default_nettype wire
